/* design/histogram_binning_engine_assert.svh */
// Assertion macros for the histogram binning engine.
// Included by the engine module, which checks its own logic; no other dependencies.
`ifndef HISTOGRAM_BINNING_ENGINE_ASSERT_SVH
`define HISTOGRAM_BINNING_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define HBE_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HBE_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define HBE_ASSERT(label, clk, rst_n, prop, msg)
`define HBE_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

/* design/hbe_pkg.sv */
// Shared types and constants for the histogram binning engine.
// No dependencies.
package hbe_pkg;

	localparam int unsigned MAX_BINS_DEF    = 254;
	localparam int unsigned COUNT_WIDTH_DEF = 32;
	localparam int unsigned SAMPLE_W        = 32;
	localparam int unsigned CFG_DATA_W      = 32;
	localparam int unsigned CFG_INDEX_W     = 2;
	localparam int unsigned BIN_W           = 8;
	localparam int unsigned NUM_BINS_W      = 8;
	localparam int unsigned OUT_COUNT_W     = 32;

	typedef enum logic [1:0] {
		KIND_ADD   = 2'd0,
		KIND_READ  = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_START_POINT   = 2'd0,
		CFG_BINS_PER_UNIT = 2'd1,
		CFG_NUM_BINS      = 2'd2
	} cfg_reg_t;

	localparam logic [SAMPLE_W-1:0]   START_POINT_RST   = 32'h0000_0000;
	localparam logic [SAMPLE_W-1:0]   BINS_PER_UNIT_RST = 32'h0001_0000;
	localparam logic [NUM_BINS_W-1:0] NUM_BINS_RST      = 8'd254;

endpackage

/* design/histogram_binning_engine.sv */
// Histogram binning engine: bins Q15.16 samples into a counter store.
// Depends on hbe_pkg and histogram_binning_engine_assert.svh.
//
//  port group          dir  handshake
//  start/kind/...      in   transfer when start && !busy
//  cfg_wr_*            in   write when cfg_wr_en
//  done/bin_*/total    out  one-cycle strobe, no backpressure
//
// One item per cycle; each result passes the stages below and then the result register.
// Pipeline: offset subtract, 32x32 multiply, bin select with store read,
// count update with write-back and forwarding of the previous write.
// busy is never raised; reset clears all counts at once via per-entry valid bits.
// The receiver cannot stall: done marks a result for exactly one cycle.
`include "histogram_binning_engine_assert.svh"

module histogram_binning_engine
	import hbe_pkg::*;
#(
	parameter int unsigned MAX_BINS    = MAX_BINS_DEF,
	parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    kind,
	input  logic signed [SAMPLE_W-1:0]    sample,
	input  logic [BIN_W-1:0]              read_index,
	input  logic                          cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	output logic                          done,
	output logic [BIN_W-1:0]              bin_index,
	output logic [OUT_COUNT_W-1:0]        bin_count,
	output logic [OUT_COUNT_W-1:0]        total_count
);

	localparam int unsigned DEPTH  = MAX_BINS + 2;
	localparam int unsigned ADDR_W = $clog2(DEPTH);

	logic [SAMPLE_W-1:0]   start_point_q;
	logic [SAMPLE_W-1:0]   bins_per_unit_q;
	logic [NUM_BINS_W-1:0] num_bins_q;

	logic                  accept;
	kind_t                 op_in;

	logic                  v_s1;
	kind_t                 op_s1;
	logic [BIN_W-1:0]      rd_idx_s1;
	logic signed [SAMPLE_W:0] offset_s1;
	logic [2*SAMPLE_W-1:0] prod_c;

	logic                  v_s2;
	kind_t                 op_s2;
	logic [BIN_W-1:0]      rd_idx_s2;
	logic                  neg_s2;
	logic [SAMPLE_W-1:0]   prod_hi_s2;

	logic [ADDR_W-1:0]     n_eff;
	logic [ADDR_W-1:0]     add_bin;
	logic [ADDR_W-1:0]     addr_c;
	logic                  in_store_c;
	logic [BIN_W-1:0]      bin_out_c;

	logic                  v_s3;
	kind_t                 op_s3;
	logic [ADDR_W-1:0]     addr_s3;
	logic                  in_store_s3;
	logic [BIN_W-1:0]      bin_out_s3;
	logic [COUNT_WIDTH-1:0] rd_data_s3;

	logic [COUNT_WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0]      valid_q;
	logic                  wr_v_q;
	logic [ADDR_W-1:0]     wr_addr_q;
	logic [COUNT_WIDTH-1:0] wr_data_q;
	logic [COUNT_WIDTH-1:0] total_q;

	logic [COUNT_WIDTH-1:0] cur_cnt;
	logic [COUNT_WIDTH-1:0] cnt_next;
	logic [COUNT_WIDTH-1:0] total_next;
	logic [COUNT_WIDTH-1:0] res_cnt;
	logic                  wr_en_c;

	logic                  done_q;
	logic [BIN_W-1:0]      bin_index_q;
	logic [OUT_COUNT_W-1:0] bin_count_q;
	logic [OUT_COUNT_W-1:0] total_count_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_comb begin
		unique case (kind)
			KIND_ADD:   op_in = KIND_ADD;
			KIND_CLEAR: op_in = KIND_CLEAR;
			default:    op_in = KIND_READ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_point_q   <= START_POINT_RST;
			bins_per_unit_q <= BINS_PER_UNIT_RST;
			num_bins_q      <= NUM_BINS_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_START_POINT:   start_point_q   <= cfg_data;
				CFG_BINS_PER_UNIT: bins_per_unit_q <= cfg_data;
				CFG_NUM_BINS:      num_bins_q      <= cfg_data[NUM_BINS_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1: offset from the range start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= op_in;
			rd_idx_s1 <= read_index;
			offset_s1 <= $signed({sample[SAMPLE_W-1], sample})
				- $signed({start_point_q[SAMPLE_W-1], start_point_q});
		end
	end

	// stage 2: scale to bin position
	assign prod_c = {{SAMPLE_W{1'b0}}, offset_s1[SAMPLE_W-1:0]}
		* {{SAMPLE_W{1'b0}}, bins_per_unit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			op_s2      <= op_s1;
			rd_idx_s2  <= rd_idx_s1;
			neg_s2     <= offset_s1[SAMPLE_W];
			prod_hi_s2 <= prod_c[2*SAMPLE_W-1:SAMPLE_W];
		end
	end

	// bin select and store read address
	always_comb begin
		if (num_bins_q == '0) begin
			n_eff = ADDR_W'(1);
		end else if ({8'd0, num_bins_q} > 16'(MAX_BINS)) begin
			n_eff = ADDR_W'(MAX_BINS);
		end else begin
			n_eff = ADDR_W'(num_bins_q);
		end

		priority if (neg_s2) begin
			add_bin = '0;
		end else if (prod_hi_s2 >= SAMPLE_W'(n_eff)) begin
			add_bin = n_eff + ADDR_W'(1);
		end else begin
			add_bin = ADDR_W'(prod_hi_s2) + ADDR_W'(1);
		end

		if (op_s2 == KIND_ADD) begin
			addr_c     = add_bin;
			in_store_c = 1'b1;
			bin_out_c  = BIN_W'(add_bin);
		end else begin
			addr_c     = ADDR_W'(rd_idx_s2);
			in_store_c = {8'd0, rd_idx_s2} < 16'(DEPTH);
			bin_out_c  = (op_s2 == KIND_CLEAR) ? '0 : rd_idx_s2;
		end
	end

	// stage 3: update count, write back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			op_s3       <= op_s2;
			addr_s3     <= addr_c;
			in_store_s3 <= in_store_c;
			bin_out_s3  <= bin_out_c;
			rd_data_s3  <= mem[addr_c];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en_c) begin
			mem[addr_s3] <= cnt_next;
		end
	end

	always_comb begin
		if (wr_v_q && (wr_addr_q == addr_s3)) begin
			cur_cnt = wr_data_q;
		end else if (in_store_s3 && valid_q[addr_s3]) begin
			cur_cnt = rd_data_s3;
		end else begin
			cur_cnt = '0;
		end

		cnt_next = (cur_cnt == '1) ? cur_cnt : cur_cnt + COUNT_WIDTH'(1);
		wr_en_c  = v_s3 && (op_s3 == KIND_ADD);

		unique case (op_s3)
			KIND_ADD: begin
				total_next = (total_q == '1) ? total_q : total_q + COUNT_WIDTH'(1);
				res_cnt    = cnt_next;
			end
			KIND_CLEAR: begin
				total_next = '0;
				res_cnt    = '0;
			end
			default: begin
				total_next = total_q;
				res_cnt    = in_store_s3 ? cur_cnt : '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			total_q <= '0;
			wr_v_q  <= 1'b0;
		end else begin
			wr_v_q <= wr_en_c;
			if (v_s3) begin
				total_q <= total_next;
			end
			if (v_s3 && (op_s3 == KIND_CLEAR)) begin
				valid_q <= '0;
			end else if (wr_en_c) begin
				valid_q[addr_s3] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en_c) begin
			wr_addr_q <= addr_s3;
			wr_data_q <= cnt_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			bin_index_q   <= bin_out_s3;
			bin_count_q   <= OUT_COUNT_W'(res_cnt);
			total_count_q <= OUT_COUNT_W'(total_next);
		end
	end

	assign done        = done_q;
	assign bin_index   = bin_index_q;
	assign bin_count   = bin_count_q;
	assign total_count = total_count_q;

	`HBE_ASSERT(a_latency, clk, arst_n, accept |=> ##3 done, "result missing four cycles after transfer")
	`HBE_ASSERT(a_total_mono, clk, arst_n, !(v_s3 && (op_s3 == KIND_CLEAR)) |=> total_q >= $past(total_q), "running total decreased without clear")
	`HBE_ASSERT_NEVER(a_add_zero, clk, arst_n, wr_en_c && (cnt_next == '0), "add produced a zero count")
	`HBE_ASSERT(a_add_in_store, clk, arst_n, wr_en_c |-> (32'(addr_s3) < 32'(DEPTH)), "add bin outside the store")

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for histogram_binning_engine: command transfers in,
// one strobed result per transfer out, each checked against an internal model.
// Depends on hbe_pkg and the engine RTL only.
`timescale 1ns / 1ps

module tb_top;
	import hbe_pkg::*;

	localparam int DEPTH = MAX_BINS_DEF + 2;
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEMS_PER_PHASE = 232;
	localparam int NUM_PHASES = 8;
	localparam logic [1:0] KIND_UNDEF = 2'd3;

	typedef struct {
		logic [BIN_W-1:0]       bin;
		logic [OUT_COUNT_W-1:0] cnt;
		logic [OUT_COUNT_W-1:0] tot;
	} bin_report_t;

	class hist_tracker;
		logic [31:0] start_q;
		logic [31:0] bpu_q;
		logic [7:0]  nbins_q;
		logic [31:0] bin_counts [DEPTH];
		logic [31:0] total_q;
		bin_report_t pending_reports [$];
		int          errors;

		function new();
			start_q = START_POINT_RST;
			bpu_q = BINS_PER_UNIT_RST;
			nbins_q = NUM_BINS_RST;
			errors = 0;
			clear_counts();
		endfunction

		function void clear_counts();
			foreach (bin_counts[i]) bin_counts[i] = '0;
			total_q = '0;
		endfunction

		function void set_register(cfg_reg_t r, logic [31:0] v);
			case (r)
				CFG_START_POINT:   start_q = v;
				CFG_BINS_PER_UNIT: bpu_q = v;
				CFG_NUM_BINS:      nbins_q = v[7:0];
				default: ;
			endcase
		endfunction

		function int unsigned active_bins();
			int unsigned n;
			n = nbins_q;
			if (n == 0) n = 1;
			if (n > MAX_BINS_DEF) n = MAX_BINS_DEF;
			return n;
		endfunction

		function logic [7:0] bin_of(logic [31:0] s);
			logic signed [32:0] off;
			logic [63:0]        prod;
			int unsigned        n;
			n = active_bins();
			off = $signed({s[31], s}) - $signed({start_q[31], start_q});
			if (off[32]) return 8'd0;
			prod = {32'd0, off[31:0]} * {32'd0, bpu_q};
			if (prod[63:32] >= n) return 8'(n + 1);
			return 8'(prod[63:32] + 1);
		endfunction

		function logic [31:0] bump(logic [31:0] c);
			return (c == '1) ? c : c + 32'd1;
		endfunction

		function void note_transfer(logic [1:0] k, logic [31:0] s, logic [7:0] idx);
			bin_report_t r;
			case (k)
				KIND_ADD: begin
					r.bin = bin_of(s);
					bin_counts[r.bin] = bump(bin_counts[r.bin]);
					r.cnt = bin_counts[r.bin];
					total_q = bump(total_q);
					r.tot = total_q;
				end
				KIND_CLEAR: begin
					clear_counts();
					r.bin = '0;
					r.cnt = '0;
					r.tot = '0;
				end
				default: begin
					r.bin = idx;
					r.cnt = (int'(idx) < DEPTH) ? bin_counts[idx] : '0;
					r.tot = total_q;
				end
			endcase
			pending_reports.insert(pending_reports.size(), r);
		endfunction

		task report(string msg);
			$display("ERROR: %s", msg);
			errors++;
		endtask

		task check_report(logic [7:0] bin, logic [31:0] cnt, logic [31:0] tot);
			bin_report_t e;
			if (pending_reports.size() == 0) begin
				report($sformatf("result with nothing outstanding: bin %0d", bin));
				return;
			end
			e = pending_reports.pop_front();
			if (bin !== e.bin)
				report($sformatf("bin_index %0d, want %0d", bin, e.bin));
			if (cnt !== e.cnt)
				report($sformatf("bin_count %0d, want %0d (bin %0d)", cnt, e.cnt, e.bin));
			if (tot !== e.tot)
				report($sformatf("total_count %0d, want %0d", tot, e.tot));
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [1:0]             kind;
	logic [SAMPLE_W-1:0]    sample;
	logic [BIN_W-1:0]       read_index;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   done;
	logic [BIN_W-1:0]       bin_index;
	logic [OUT_COUNT_W-1:0] bin_count;
	logic [OUT_COUNT_W-1:0] total_count;

	hist_tracker tracker = new();
	int          transfers = 0;
	int          cycles = 0;

	histogram_binning_engine i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.sample      (sample),
		.read_index  (read_index),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.done        (done),
		.bin_index   (bin_index),
		.bin_count   (bin_count),
		.total_count (total_count)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				tracker.note_transfer(kind, sample, read_index);
				transfers++;
			end
			if (done)
				tracker.check_report(bin_index, bin_count, total_count);
		end
	end

	task automatic send_item(logic [1:0] k, logic [31:0] s, logic [7:0] idx);
		int n0;
		n0 = transfers;
		start <= 1'b1;
		kind <= k;
		sample <= s;
		read_index <= idx;
		@(negedge clk);
		while (transfers == n0) @(negedge clk);
	endtask

	task automatic pause(int n);
		start <= 1'b0;
		kind <= 2'($urandom);
		sample <= $urandom;
		read_index <= 8'($urandom);
		repeat (n) @(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (tracker.pending_reports.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_settings(logic [31:0] sp, logic [31:0] bpu, logic [7:0] nb);
		logic [31:0] nb_word;
		nb_word = {$urandom} << 8 | 32'(nb);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_START_POINT;
		cfg_data <= sp;
		@(negedge clk);
		cfg_index <= CFG_BINS_PER_UNIT;
		cfg_data <= bpu;
		@(negedge clk);
		cfg_index <= CFG_NUM_BINS;
		cfg_data <= nb_word;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		tracker.set_register(CFG_START_POINT, sp);
		tracker.set_register(CFG_BINS_PER_UNIT, bpu);
		tracker.set_register(CFG_NUM_BINS, nb_word);
		@(negedge clk);
	endtask

	function automatic logic [31:0] near_sample();
		int unsigned n;
		logic [63:0] span;
		logic [63:0] off;
		logic [63:0] k;
		logic [31:0] b;
		b = tracker.bpu_q;
		n = tracker.active_bins();
		if (b == 0 || $urandom_range(0, 9) == 0) return $urandom;
		span = ({32'd0, n} << 32) / {32'd0, b};
		if (span > 64'h1_0000_0000) span = 64'h1_0000_0000;
		case ($urandom_range(0, 3))
			0: begin
				k = 64'($urandom_range(0, n));
				off = ((k << 32) + 64'(b) - 64'd1) / 64'(b);
				off = off + 64'($urandom_range(0, 2)) - 64'd1;
			end
			1: off = 64'd0 - 64'($urandom_range(1, 1000));
			default: off = {$urandom, $urandom} % (span + span / 8 + 64'd1);
		endcase
		return tracker.start_q + off[31:0];
	endfunction

	task automatic random_item();
		int unsigned n;
		int          pick;
		logic [7:0]  idx;
		n = tracker.active_bins();
		pick = $urandom_range(0, 99);
		idx = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, n + 1)) : 8'($urandom);
		if (pick < 70)
			send_item(KIND_ADD, near_sample(), 8'($urandom));
		else if (pick < 94)
			send_item(KIND_READ, $urandom, idx);
		else if (pick < 97)
			send_item(KIND_UNDEF, $urandom, idx);
		else
			send_item(KIND_CLEAR, $urandom, 8'($urandom));
	endtask

	task automatic run_random(int count);
		int sent;
		int burst;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 40);
			while (burst > 0 && sent < count) begin
				random_item();
				burst--;
				sent++;
			end
			if (sent == count / 2)
				drain();
			else if ($urandom_range(0, 9) >= 3)
				pause($urandom_range(1, 6));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_ADD;
		sample = '0;
		read_index = '0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_START_POINT;
		cfg_data = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// default range: unit-wide bins from zero
		send_item(KIND_ADD, 32'h0000_0000, 8'hFF);
		send_item(KIND_ADD, 32'hFFFF_FFFF, 8'h00);
		send_item(KIND_ADD, 32'h8000_0000, 8'h00);
		send_item(KIND_ADD, 32'h7FFF_FFFF, 8'h00);
		send_item(KIND_ADD, 32'h00FD_0000, 8'h00);
		send_item(KIND_ADD, 32'h00FD_FFFF, 8'h00);
		send_item(KIND_ADD, 32'h00FE_0000, 8'h00);
		send_item(KIND_ADD, 32'h0001_8000, 8'h00);
		send_item(KIND_ADD, 32'h0005_0000, 8'h00);
		send_item(KIND_ADD, 32'h0005_0000, 8'h00);
		send_item(KIND_READ, 32'hFFFF_FFFF, 8'd6);
		send_item(KIND_READ, 32'h0000_0000, 8'd0);
		send_item(KIND_READ, 32'h0000_0000, 8'd1);
		send_item(KIND_READ, 32'h0000_0000, 8'd254);
		send_item(KIND_READ, 32'h0000_0000, 8'd255);
		send_item(KIND_UNDEF, 32'h0000_0000, 8'd2);
		send_item(KIND_CLEAR, 32'hFFFF_FFFF, 8'hFF);
		send_item(KIND_READ, 32'h0000_0000, 8'd255);
		send_item(KIND_ADD, 32'h0005_0000, 8'h00);
		send_item(KIND_READ, 32'h0000_0000, 8'd6);
		drain();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				1: write_settings(32'h8000_0000, 32'hFFFF_FFFF, 8'd0);
				2: write_settings(32'h7FFF_FFFF, 32'h0000_0000, 8'd255);
				3: write_settings(32'hFFF6_0000, 32'h0001_0000, 8'd20);
				4: write_settings(32'h0000_0000, 32'h0000_8000, 8'd1);
				5: write_settings($urandom, 32'($urandom_range(1, 32'h0100_0000)),
					8'($urandom_range(1, 254)));
				6: write_settings($urandom, $urandom, 8'd254);
				7: write_settings(32'hFFF0_0000, 32'h0010_0000, 8'd254);
				default: ;
			endcase
			run_random(ITEMS_PER_PHASE);
			drain();
		end

		if (tracker.errors == 0 && tracker.pending_reports.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
